/* sv/ssma_pkg.sv */
// Shared types and constants of the stable-sample moving average.
package ssma_pkg;

    localparam int NOISE_W = 10;
    localparam int MATCH_W = 4;
    localparam int OUT_W   = 14;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    localparam logic [NOISE_W-1:0] NOISE_RST = 10'd3;
    localparam logic [MATCH_W-1:0] MATCH_RST = 4'd3;

    // Register index, taken from paddr[2].
    typedef enum logic {
        REG_NOISE = 1'b0,
        REG_MATCH = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [NOISE_W-1:0] noise_thr;
        logic [MATCH_W-1:0] required_matches;
    } t_cfg;

endpackage

/* sv/ssma_cfg.sv */
// APB register file holding the noise level and the required match count.
module ssma_cfg
    import ssma_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[2]);
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.noise_thr        <= NOISE_RST;
            r_cfg.required_matches <= MATCH_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_NOISE: r_cfg.noise_thr        <= pwdata[NOISE_W-1:0];
                REG_MATCH: r_cfg.required_matches <= pwdata[MATCH_W-1:0];
                default:   r_cfg                  <= r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_NOISE: prdata = APB_DW'(r_cfg.noise_thr);
            REG_MATCH: prdata = APB_DW'(r_cfg.required_matches);
            default:   prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

/* sv/ssma_core.sv */
// Input register, debounce state, ring and running sum.
module ssma_core
    import ssma_pkg::*;
#(
    parameter int RING_DEPTH  = 10,
    parameter int SAMPLE_BITS = 10,
    parameter int SUM_W       = SAMPLE_BITS + $clog2(RING_DEPTH)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cfg                   i_cfg,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [SUM_W-1:0]       o_sum,
    output logic                   o_stored
);

    localparam int WP_W  = $clog2(RING_DEPTH);
    localparam int CMP_W = (SAMPLE_BITS > NOISE_W) ? SAMPLE_BITS : NOISE_W;

    logic                   r_in_valid;
    logic [SAMPLE_BITS-1:0] r_in_sample;
    logic [SAMPLE_BITS-1:0] r_cand, n_cand;
    logic [MATCH_W-1:0]     r_count, n_count;
    logic [SAMPLE_BITS-1:0] r_ring [RING_DEPTH];
    logic [WP_W-1:0]        r_wptr, n_wptr;
    logic [SUM_W-1:0]       r_sum, n_sum;
    logic                   r_mid_valid;
    logic [SUM_W-1:0]       r_mid_sum;
    logic                   r_mid_stored;

    logic                   w_go;
    logic                   w_mid_ready;
    logic [SAMPLE_BITS-1:0] w_diff;
    logic                   w_match;
    logic [MATCH_W-1:0]     w_cnt_inc;
    logic                   w_commit;

    assign w_mid_ready = !r_mid_valid || i_ready;
    assign w_go        = r_in_valid && w_mid_ready;
    assign o_ready     = !r_in_valid || w_mid_ready;

    always_comb begin
        w_diff    = (r_cand >= r_in_sample) ? (r_cand - r_in_sample) : (r_in_sample - r_cand);
        w_match   = (r_count != '0) && (CMP_W'(w_diff) < CMP_W'(i_cfg.noise_thr));
        w_cnt_inc = r_count + MATCH_W'(1);
        w_commit  = w_match && (w_cnt_inc >= i_cfg.required_matches);

        n_cand  = r_cand;
        n_count = r_count;
        n_wptr  = r_wptr;
        n_sum   = r_sum;
        priority if (!w_match) begin
            // Empty count or a mismatch: restart on this sample.
            n_cand  = r_in_sample;
            n_count = MATCH_W'(1);
        end else if (w_commit) begin
            n_count = '0;
            n_sum   = r_sum - SUM_W'(r_ring[r_wptr]) + SUM_W'(r_cand);
            n_wptr  = (r_wptr == WP_W'(RING_DEPTH - 1)) ? '0 : r_wptr + WP_W'(1);
        end else begin
            n_count = w_cnt_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_mid_valid <= 1'b0;
            r_cand      <= '0;
            r_count     <= '0;
            r_wptr      <= '0;
            r_sum       <= '0;
            for (int i = 0; i < RING_DEPTH; i++) begin
                r_ring[i] <= '0;
            end
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (w_mid_ready) begin
                r_mid_valid <= w_go;
            end
            if (w_go) begin
                r_cand  <= n_cand;
                r_count <= n_count;
                r_wptr  <= n_wptr;
                r_sum   <= n_sum;
                if (w_commit) begin
                    r_ring[r_wptr] <= r_cand;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_sample <= i_sample;
        end
        if (w_go) begin
            r_mid_sum    <= n_sum;
            r_mid_stored <= w_commit;
        end
    end

    assign o_valid  = r_mid_valid;
    assign o_sum    = r_mid_sum;
    assign o_stored = r_mid_stored;

    a_wptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wptr <= WP_W'(RING_DEPTH - 1))
        else $error("ring write pointer out of range");

    a_commit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_go && w_commit |=> r_count == '0 && r_mid_stored)
        else $error("commit did not clear the match count");

    a_restart_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_go && !w_match |=> r_count == MATCH_W'(1) && !r_mid_stored)
        else $error("restart did not set the count to one");

    a_sum_moves_on_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_go && !w_commit |=> $stable(r_sum))
        else $error("running sum changed without a commit");

endmodule

/* sv/ssma_avg.sv */
// Output stage: average by reciprocal multiply, result register.
module ssma_avg
    import ssma_pkg::*;
#(
    parameter int RING_DEPTH  = 10,
    parameter int SAMPLE_BITS = 10,
    parameter int SUM_W       = SAMPLE_BITS + $clog2(RING_DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [SUM_W-1:0] i_sum,
    input  logic             i_stored,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [OUT_W-1:0] o_window_sum,
    output logic [OUT_W-1:0] o_average_q4,
    output logic             o_stored
);

    // floor(16*sum/D) = floor(sum*M / 2^(K-4)) with M = ceil(2^K/D); exact for
    // K >= width(16*sum) + log2(D).
    localparam int          K    = SUM_W + 4 + $clog2(RING_DEPTH);
    localparam int          M_W  = K + 1;
    localparam longint      M    = ((64'd1 << K) + RING_DEPTH - 1) / RING_DEPTH;
    localparam int          P_W  = SUM_W + M_W;

    logic [P_W-1:0]   w_prod;
    logic             r_valid;
    logic [OUT_W-1:0] r_sum;
    logic [OUT_W-1:0] r_avg;
    logic             r_stored;

    assign w_prod  = P_W'(i_sum) * P_W'(M_W'(M));
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_sum    <= OUT_W'(i_sum);
            r_avg    <= w_prod[K-4 +: OUT_W];
            r_stored <= i_stored;
        end
    end

    assign o_valid      = r_valid;
    assign o_window_sum = r_sum;
    assign o_average_q4 = r_avg;
    assign o_stored     = r_stored;

    a_take_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> r_valid)
        else $error("accepted word not presented");

    a_avg_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && (RING_DEPTH >= 16) |-> r_avg <= r_sum)
        else $error("average exceeds sum for a deep ring");

    a_zero_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_sum == '0 && (SUM_W <= OUT_W) |-> r_avg == '0)
        else $error("nonzero average of an empty sum");

endmodule

/* sv/stable_sample_moving_average.sv */
// A word accepted into the input register passes the middle register, then the output result register.
// Throughput: one word per cycle while the output is not stalled, set by the combinational state update loop
// (match test, ring read and running-sum add) between input and middle register.
// The average uses one registered reciprocal multiply in the output stage.
// Synchronous active-low reset clears the candidate, count, ring, pointer and sum
// and sets noise level and required matches to 3; no clearing pass is needed.
module stable_sample_moving_average
    import ssma_pkg::*;
#(
    parameter int RING_DEPTH  = 10,
    parameter int SAMPLE_BITS = 10
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [APB_AW-1:0]                    paddr,
    input  logic [APB_DW-1:0]                    pwdata,
    output logic [APB_DW-1:0]                    prdata,
    output logic                                 pready,
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    // Fields from bit 0: adc_sample, zero padding.
    input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] i_s_tdata,
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    // Fields from bit 0: window_sum, average_q4, zero padding.
    output logic [31:0]                          o_m_tdata,
    // Fields from bit 0: stored.
    output logic                                 o_m_tuser
);

    localparam int SUM_W = SAMPLE_BITS + $clog2(RING_DEPTH);

    t_cfg             w_cfg;
    logic             w_mid_valid;
    logic             w_mid_ready;
    logic [SUM_W-1:0] w_mid_sum;
    logic             w_mid_stored;
    logic [OUT_W-1:0] w_window_sum;
    logic [OUT_W-1:0] w_average_q4;

    ssma_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    ssma_core #(
        .RING_DEPTH  (RING_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS),
        .SUM_W       (SUM_W)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_valid  (i_s_tvalid),
        .o_ready  (o_s_tready),
        .i_sample (i_s_tdata[SAMPLE_BITS-1:0]),
        .o_valid  (w_mid_valid),
        .i_ready  (w_mid_ready),
        .o_sum    (w_mid_sum),
        .o_stored (w_mid_stored)
    );

    ssma_avg #(
        .RING_DEPTH  (RING_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS),
        .SUM_W       (SUM_W)
    ) u_avg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_mid_valid),
        .o_ready      (w_mid_ready),
        .i_sum        (w_mid_sum),
        .i_stored     (w_mid_stored),
        .o_valid      (o_m_tvalid),
        .i_ready      (i_m_tready),
        .o_window_sum (w_window_sum),
        .o_average_q4 (w_average_q4),
        .o_stored     (o_m_tuser)
    );

    assign o_m_tdata = {4'b0000, w_average_q4, w_window_sum};

endmodule
